// File: src/ebr_pkg.sv
// Shared definitions for the ellipse rasterizer core.
// Depends on nothing; used by ebr_step, ebr_out and the top level.
package ebr_pkg;

    localparam int AXIS_WIDTH_DEF  = 10;
    localparam int COORD_WIDTH_DEF = 16;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    // number of mirrored points in one group
    localparam int GROUP_SIZE = 4;
    localparam int GROUP_IDX_W = $clog2(GROUP_SIZE);

    // control from the step engine to the result buffer
    typedef struct packed {
        logic load;   // a point group is ready to be buffered
        logic done;   // the group is the ellipse's final one
    } t_grp_ctl;

endpackage

// File: src/ebr_step.sv
// One rasteriser step: mirrored points of the current point and the next
// (x, y, error) by the diagonal, horizontal or vertical choice. Uses ebr_pkg widths only.
module ebr_step #(
    parameter int AW = ebr_pkg::AXIS_WIDTH_DEF,
    parameter int CW = ebr_pkg::COORD_WIDTH_DEF
) (
    input  logic        [AW:0]       i_cur_x,
    input  logic signed [AW+1:0]     i_cur_y,
    input  logic signed [2*AW+15:0]  i_err,
    input  logic        [2*AW-1:0]   i_a2,
    input  logic        [2*AW-1:0]   i_b2,
    input  logic signed [3*AW+2:0]   i_ay,
    input  logic signed [3*AW+2:0]   i_bx,
    input  logic signed [CW-1:0]     i_ctr_x,
    input  logic signed [CW-1:0]     i_ctr_y,
    output logic        [AW:0]       o_n_cur_x,
    output logic signed [AW+1:0]     o_n_cur_y,
    output logic signed [2*AW+15:0]  o_n_err,
    output logic signed [3*AW+2:0]   o_n_ay,
    output logic signed [3*AW+2:0]   o_n_bx,
    output logic signed [CW:0]       o_px_p,
    output logic signed [CW:0]       o_px_m,
    output logic signed [CW:0]       o_py_p,
    output logic signed [CW:0]       o_py_m,
    output logic                     o_done
);
    localparam int EW = 2 * AW + 16;
    localparam int PW = 3 * AW + 3;
    localparam int TW = ((PW > EW) ? PW : EW) + 3;
    localparam int OW = CW + 1;

    logic signed [TW-1:0] w_a, w_b, w_d, w_ay, w_bx;
    logic signed [TW-1:0] w_ay_dec, w_bx_inc;
    logic signed [TW-1:0] w_t_neg, w_t_pos;
    logic signed [TW-1:0] w_d_diag, w_d_horiz, w_d_vert;
    logic                 w_d_neg, w_d_zero, w_t_le;
    logic                 w_step_x, w_step_y;
    logic signed [OW-1:0] w_cx, w_cy, w_x, w_y;

    always_comb begin
        w_a      = TW'(i_a2);
        w_b      = TW'(i_b2);
        w_d      = TW'(i_err);
        w_ay     = TW'(i_ay);
        w_bx     = TW'(i_bx);
        // A*y and B*x are tracked incrementally: A*(y-1), B*(x+1)
        w_ay_dec = w_ay - w_a;
        w_bx_inc = w_bx + w_b;

        w_t_neg  = ((w_d + w_ay) <<< 1) - w_a;
        w_t_pos  = ((w_d - w_bx) <<< 1) - w_b;

        w_d_diag  = w_d + ((w_bx_inc - w_ay_dec) <<< 1) + w_a + w_b;
        w_d_horiz = w_d + (w_bx_inc <<< 1) + w_b;
        w_d_vert  = w_d - (w_ay_dec <<< 1) + w_a;

        w_d_neg  = w_d[TW-1];
        w_d_zero = (w_d == '0);

        if (w_d_neg) begin
            w_t_le   = w_t_neg[TW-1] || (w_t_neg == '0);
            w_step_x = 1'b1;
            w_step_y = !w_t_le;
        end else if (!w_d_zero) begin
            w_t_le   = w_t_pos[TW-1] || (w_t_pos == '0);
            w_step_x = w_t_le;
            w_step_y = 1'b1;
        end else begin
            w_t_le   = 1'b0;
            w_step_x = 1'b1;
            w_step_y = 1'b1;
        end

        if (w_step_x && w_step_y) begin
            o_n_err = EW'(w_d_diag);
        end else if (w_step_x) begin
            o_n_err = EW'(w_d_horiz);
        end else begin
            o_n_err = EW'(w_d_vert);
        end

        o_n_cur_x = i_cur_x + (AW+1)'(w_step_x);
        o_n_cur_y = i_cur_y - (AW+2)'(w_step_y);
        o_n_ay    = w_step_y ? PW'(w_ay_dec) : i_ay;
        o_n_bx    = w_step_x ? PW'(w_bx_inc) : i_bx;
        o_done    = o_n_cur_y[AW+1];

        w_cx   = OW'(i_ctr_x);
        w_cy   = OW'(i_ctr_y);
        w_x    = OW'(i_cur_x);
        w_y    = OW'(i_cur_y);
        o_px_p = w_cx + w_x;
        o_px_m = w_cx - w_x;
        o_py_p = w_cy + w_y;
        o_py_m = w_cy - w_y;
    end

endmodule

// File: src/ebr_out.sv
// Result buffer: holds a group of four mirrored points; sends one per cycle
// while ready on a valid/ready channel. Uses ebr_pkg for t_grp_ctl.
module ebr_out #(
    parameter int OW = ebr_pkg::COORD_WIDTH_DEF + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ebr_pkg::t_grp_ctl     i_ctl,
    input  logic signed [OW-1:0]  i_px_p,
    input  logic signed [OW-1:0]  i_px_m,
    input  logic signed [OW-1:0]  i_py_p,
    input  logic signed [OW-1:0]  i_py_m,
    output logic                  o_can_load,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [OW-1:0]  o_point_x,
    output logic signed [OW-1:0]  o_point_y,
    output logic                  o_last,
    output logic                  o_done_res
);
    localparam logic [ebr_pkg::GROUP_IDX_W-1:0] IDX_LAST =
        ebr_pkg::GROUP_IDX_W'(ebr_pkg::GROUP_SIZE - 1);

    logic                             r_full;
    logic [ebr_pkg::GROUP_IDX_W-1:0]  r_idx;
    logic                             r_done;
    logic signed [OW-1:0]             r_px_p, r_px_m, r_py_p, r_py_m;
    logic                             w_xfer, w_drain;

    assign w_xfer     = r_full && i_ready;
    assign w_drain    = w_xfer && (r_idx == IDX_LAST);
    assign o_can_load = !r_full || w_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (i_ctl.load) begin
                r_full <= 1'b1;
                r_idx  <= '0;
            end else if (w_drain) begin
                r_full <= 1'b0;
                r_idx  <= '0;
            end else if (w_xfer) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_px_p <= i_px_p;
            r_px_m <= i_px_m;
            r_py_p <= i_py_p;
            r_py_m <= i_py_m;
            r_done <= i_ctl.done;
        end
    end

    // order: (+x,+y), (-x,+y), (-x,-y), (+x,-y)
    always_comb begin
        case (r_idx)
            2'd0: begin
                o_point_x = r_px_p;
                o_point_y = r_py_p;
            end
            2'd1: begin
                o_point_x = r_px_m;
                o_point_y = r_py_p;
            end
            2'd2: begin
                o_point_x = r_px_m;
                o_point_y = r_py_m;
            end
            default: begin
                o_point_x = r_px_p;
                o_point_y = r_py_m;
            end
        endcase
    end

    assign o_valid    = r_full;
    assign o_last     = (r_idx == IDX_LAST);
    assign o_done_res = r_done;

endmodule

// File: src/ellipse_bresenham_rasterizer_core.sv
// Top level of the ellipse rasteriser: input register, step engine, result buffer.
// Depends on ebr_pkg, ebr_step and ebr_out.
//
// Use:
//   Input channel i_valid/o_ready carries a request. A start request
//   (i_req_type = 0) latches the centre and the semi-axes and yields no
//   output. A next request (i_req_type = 1) yields four points, the mirror
//   images of the current first-quadrant point, in the order (+x,+y),
//   (-x,+y), (-x,-y), (+x,-y); o_last marks the fourth, o_done_res marks all
//   four of the final group. A next request while no ellipse runs is
//   consumed silently. A start while an ellipse runs abandons it.
//   A group's first point is valid once its request has left the input register
//   and the group is loaded into the result buffer. A next request is bound by
//   the single output port, one point per cycle while ready; a start adds a
//   set-up cycle forming a^2*b for the initial error and product registers.
//   The input register takes the next request while the buffered group is
//   still draining. If the receiver stalls, the group holds and the block
//   stops taking further next requests once one is waiting.
//   Reset (synchronous, active low) empties all stages and leaves no ellipse
//   running.
module ellipse_bresenham_rasterizer_core #(
    parameter int AXIS_WIDTH  = ebr_pkg::AXIS_WIDTH_DEF,
    parameter int COORD_WIDTH = ebr_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic        [AXIS_WIDTH-1:0]  i_semi_a,
    input  logic        [AXIS_WIDTH-1:0]  i_semi_b,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH:0]   o_point_x,
    output logic signed [COORD_WIDTH:0]   o_point_y,
    output logic                          o_last,
    output logic                          o_done_res
);
    localparam int AW = AXIS_WIDTH;
    localparam int EW = 2 * AW + 16;
    localparam int SW = 2 * AW;
    localparam int PW = 3 * AW + 3;
    localparam int OW = COORD_WIDTH + 1;

    // input register
    logic                          r_in_valid;
    logic                          r_in_req;
    logic signed [COORD_WIDTH-1:0] r_in_cx, r_in_cy;
    logic        [AW-1:0]          r_in_a, r_in_b;

    // ellipse state
    logic                          r_active;
    logic                          r_init_pend;
    logic        [AW:0]            r_cur_x;
    logic signed [AW+1:0]          r_cur_y;
    logic signed [EW-1:0]          r_err;
    logic        [SW-1:0]          r_a2, r_b2;
    logic signed [PW-1:0]          r_ay, r_bx;
    logic signed [COORD_WIDTH-1:0] r_ctr_x, r_ctr_y;

    logic                          w_is_start, w_take, w_can_load;
    logic [3*AW-1:0]               w_a2b;
    ebr_pkg::t_grp_ctl             w_ctl;

    logic        [AW:0]            n_cur_x;
    logic signed [AW+1:0]          n_cur_y;
    logic signed [EW-1:0]          n_err;
    logic signed [PW-1:0]          n_ay, n_bx;
    logic signed [OW-1:0]          w_px_p, w_px_m, w_py_p, w_py_m;
    logic                          w_done;

    assign w_is_start = (r_in_req == ebr_pkg::REQ_START);
    assign w_take     = r_in_valid && !r_init_pend && (w_is_start || !r_active || w_can_load);
    assign o_ready    = !r_in_valid || w_take;
    assign w_ctl.load = w_take && !w_is_start && r_active;
    assign w_ctl.done = w_done;

    // y holds b during the set-up cycle
    assign w_a2b = r_a2 * r_cur_y[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_active    <= 1'b0;
            r_init_pend <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            r_init_pend <= w_take && w_is_start;
            if (w_take && w_is_start) begin
                r_active <= 1'b1;
            end else if (w_ctl.load) begin
                r_active <= !w_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_req <= i_req_type;
            r_in_cx  <= i_center_x;
            r_in_cy  <= i_center_y;
            r_in_a   <= i_semi_a;
            r_in_b   <= i_semi_b;
        end
        if (w_take && w_is_start) begin
            r_a2    <= r_in_a * r_in_a;
            r_b2    <= r_in_b * r_in_b;
            r_cur_x <= '0;
            r_cur_y <= (AW+2)'(r_in_b);
            r_ctr_x <= r_in_cx;
            r_ctr_y <= r_in_cy;
        end
        if (r_init_pend) begin
            r_err <= EW'(r_a2) + EW'(r_b2) - (EW'(w_a2b) <<< 1);
            r_ay  <= PW'(w_a2b);
            r_bx  <= '0;
        end
        if (w_ctl.load) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_err   <= n_err;
            r_ay    <= n_ay;
            r_bx    <= n_bx;
        end
    end

    ebr_step #(
        .AW (AXIS_WIDTH),
        .CW (COORD_WIDTH)
    ) u_step (
        .i_cur_x   (r_cur_x),
        .i_cur_y   (r_cur_y),
        .i_err     (r_err),
        .i_a2      (r_a2),
        .i_b2      (r_b2),
        .i_ay      (r_ay),
        .i_bx      (r_bx),
        .i_ctr_x   (r_ctr_x),
        .i_ctr_y   (r_ctr_y),
        .o_n_cur_x (n_cur_x),
        .o_n_cur_y (n_cur_y),
        .o_n_err   (n_err),
        .o_n_ay    (n_ay),
        .o_n_bx    (n_bx),
        .o_px_p    (w_px_p),
        .o_px_m    (w_px_m),
        .o_py_p    (w_py_p),
        .o_py_m    (w_py_m),
        .o_done    (w_done)
    );

    ebr_out #(
        .OW (OW)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_px_p     (w_px_p),
        .i_px_m     (w_px_m),
        .i_py_p     (w_py_p),
        .i_py_m     (w_py_m),
        .o_can_load (w_can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y),
        .o_last     (o_last),
        .o_done_res (o_done_res)
    );

    // set-up cycle blocks the engine
    a_init_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init_pend |-> !w_take)
        else $error("request taken during set-up cycle");

    a_start_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_is_start) |=> (r_init_pend && r_active))
        else $error("start not followed by set-up");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load |-> w_can_load)
        else $error("point group loaded over an undrained group");

    a_active_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> !r_cur_y[AW+1])
        else $error("running ellipse with negative y");

endmodule

// File: sim/ellipse_bresenham_rasterizer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for ellipse_bresenham_rasterizer_core: directed table, then
// random start/next sequences checked against a behavioural ellipse stepper.
// Depends on ebr_pkg and the core RTL.
module ellipse_bresenham_rasterizer_core_tb;

    localparam int AW             = ebr_pkg::AXIS_WIDTH_DEF;
    localparam int CW             = ebr_pkg::COORD_WIDTH_DEF;
    localparam int EW             = 2 * AW + 16;
    localparam int NUM_ITEMS      = 420;
    localparam int CALM_ITEMS     = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct packed {
        logic signed [CW:0] px;
        logic signed [CW:0] py;
        logic               last;
        logic               done;
    } t_pt;

    // typed rows carry the first-quadrant offset of the group they should emit
    typedef struct packed {
        logic                 rq;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic        [AW-1:0] a;
        logic        [AW-1:0] b;
        bit                   typed;
        bit                   grp;
        int                   dx;
        int                   dy;
        bit                   fin;
    } t_row;

    localparam int DIR_ROWS = 26;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 i_req_type = ebr_pkg::REQ_START;
    logic signed [CW-1:0] i_center_x = '0;
    logic signed [CW-1:0] i_center_y = '0;
    logic        [AW-1:0] i_semi_a   = '0;
    logic        [AW-1:0] i_semi_b   = '0;
    logic                 i_ready    = 1'b1;
    logic                 o_ready;
    logic                 o_valid;
    logic signed [CW:0]   o_point_x;
    logic signed [CW:0]   o_point_y;
    logic                 o_last;
    logic                 o_done_res;

    // stepper state
    logic signed [CW-1:0] ell_cx, ell_cy;
    logic        [2*AW-1:0] ell_asq, ell_bsq;
    logic        [AW:0]   ell_x;
    logic signed [AW+1:0] ell_y;
    logic signed [EW-1:0] ell_err;
    bit                   ell_live;

    t_pt pending_pts[$];
    t_pt want;
    int  errors      = 0;
    int  live_items  = 0;
    int  idle_cycles = 0;
    int  rx_hold     = 0;
    bit  tx_busy     = 1'b0;
    bit  rx_busy     = 1'b0;

    t_row dir_tab [DIR_ROWS] = '{
        // rq              cx         cy         a         b         typ   grp   dx dy    fin
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b1, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_START, 16'sd0,    16'sd0,    10'd0,    10'd0,    1'b1, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b1, 1'b1, 0, 0,    1'b1},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd1023, 10'd1023, 1'b1, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_START, 16'sh7fff, 16'sh8000, 10'd1023, 10'd1023, 1'b1, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sh7fff, 16'sh8000, 10'd0,    10'd0,    1'b1, 1'b1, 0, 1023, 1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sh7fff, 16'sh8000, 10'd0,    10'd0,    1'b0, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sh7fff, 16'sh8000, 10'd0,    10'd0,    1'b0, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_START, 16'sh8000, 16'sh7fff, 10'd1023, 10'd0,    1'b1, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sh8000, 16'sh7fff, 10'd0,    10'd0,    1'b1, 1'b1, 0, 0,    1'b1},
        '{ebr_pkg::REQ_START, 16'sd0,    16'sd0,    10'd0,    10'd3,    1'b1, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b1, 1'b1, 0, 3,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b1, 1'b1, 0, 2,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b1, 1'b1, 0, 1,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b1, 1'b1, 0, 0,    1'b1},
        '{ebr_pkg::REQ_START, 16'sd0,    16'sd0,    10'd1,    10'd1,    1'b1, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b1, 1'b1, 0, 1,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b1, 1'b1, 1, 0,    1'b1},
        '{ebr_pkg::REQ_START, 16'sd100,  -16'sd50,  10'd5,    10'd3,    1'b0, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b0, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b0, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b0, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_START, -16'sd7,   16'sd9,    10'd2,    10'd2,    1'b0, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b0, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b0, 1'b0, 0, 0,    1'b0},
        '{ebr_pkg::REQ_NEXT,  16'sd0,    16'sd0,    10'd0,    10'd0,    1'b0, 1'b0, 0, 0,    1'b0}
    };

    ellipse_bresenham_rasterizer_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_semi_a   (i_semi_a),
        .i_semi_b   (i_semi_b),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y),
        .o_last     (o_last),
        .o_done_res (o_done_res)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_pt mirror_pt(longint cx, longint cy, longint x, longint y,
                                      int k, bit fin);
        t_pt p;
        p.px   = (CW+1)'(cx + ((k == 1 || k == 2) ? -x : x));
        p.py   = (CW+1)'(cy + ((k < 2) ? y : -y));
        p.last = (k == ebr_pkg::GROUP_SIZE - 1);
        p.done = fin;
        return p;
    endfunction

    // one request through the stepper; the group is queued only when keep is set
    task automatic plot_step(input t_row r, input bit keep);
        longint asq, bsq, x, y, d, t, x0, y0;
        bit     fin;
        if (r.rq == ebr_pkg::REQ_START) begin
            asq      = longint'(r.a) * longint'(r.a);
            bsq      = longint'(r.b) * longint'(r.b);
            ell_cx   = r.cx;
            ell_cy   = r.cy;
            ell_asq  = (2*AW)'(asq);
            ell_bsq  = (2*AW)'(bsq);
            ell_x    = '0;
            ell_y    = {2'b00, r.b};
            ell_err  = EW'(asq + bsq - 2 * asq * longint'(r.b));
            ell_live = 1'b1;
        end else if (ell_live) begin
            asq = longint'(ell_asq);
            bsq = longint'(ell_bsq);
            x   = longint'(ell_x);
            y   = longint'(ell_y);
            d   = longint'(ell_err);
            x0  = x;
            y0  = y;
            if (d < 0) begin
                t = 2 * (d + asq * y) - asq;
                x = x + 1;
                if (t <= 0) begin
                    d = d + 2 * bsq * x + bsq;
                end else begin
                    y = y - 1;
                    d = d + 2 * (bsq * x - asq * y) + asq + bsq;
                end
            end else if (d > 0) begin
                t = 2 * (d - bsq * x) - bsq;
                y = y - 1;
                if (t <= 0) begin
                    x = x + 1;
                    d = d + 2 * (bsq * x - asq * y) + asq + bsq;
                end else begin
                    d = d - 2 * asq * y + asq;
                end
            end else begin
                // zero error: diagonal
                x = x + 1;
                y = y - 1;
                d = d + 2 * (bsq * x - asq * y) + asq + bsq;
            end
            fin      = (y < 0);
            ell_x    = (AW+1)'(x);
            ell_y    = (AW+2)'(y);
            ell_err  = EW'(d);
            ell_live = !fin;
            if (keep) begin
                for (int k = 0; k < ebr_pkg::GROUP_SIZE; k++)
                    pending_pts.push_back(mirror_pt(longint'(ell_cx), longint'(ell_cy),
                                                    x0, y0, k, fin));
            end
        end
    endtask

    // drive one request, wait for its transfer, then book its expected points
    task automatic issue(input t_row r);
        if (tx_busy && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= r.rq;
        i_center_x <= r.cx;
        i_center_y <= r.cy;
        i_semi_a   <= r.a;
        i_semi_b   <= r.b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (r.rq == ebr_pkg::REQ_START || ell_live)
            live_items++;
        plot_step(r, !r.typed);
        if (r.typed && r.grp) begin
            for (int k = 0; k < ebr_pkg::GROUP_SIZE; k++)
                pending_pts.push_back(mirror_pt(longint'(r.cx), longint'(r.cy),
                                                longint'(r.dx), longint'(r.dy), k, r.fin));
        end
    endtask

    function automatic t_row rand_row(logic rq, int amax);
        t_row r;
        r    = '0;
        r.rq = rq;
        r.cx = CW'($urandom);
        r.cy = CW'($urandom);
        r.a  = AW'($urandom_range(0, amax));
        r.b  = AW'($urandom_range(0, amax));
        return r;
    endfunction

    // receiver: random stall bursts while busy
    always @(posedge i_clk) begin
        if (!i_rst_n || !rx_busy) begin
            i_ready <= 1'b1;
            rx_hold <= 0;
        end else if (rx_hold != 0) begin
            i_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_ready <= 1'b0;
            rx_hold <= $urandom_range(0, 9);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pts.size() == 0) begin
                $error("unexpected point: x %0d, y %0d", o_point_x, o_point_y);
                errors++;
            end else begin
                want = pending_pts.pop_front();
                if (o_point_x !== want.px) begin
                    $error("point_x: expected %0d, got %0d", want.px, o_point_x);
                    errors++;
                end
                if (o_point_y !== want.py) begin
                    $error("point_y: expected %0d, got %0d", want.py, o_point_y);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    errors++;
                end
                if (o_done_res !== want.done) begin
                    $error("done_res: expected %0d, got %0d", want.done, o_done_res);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int  steps;
        bit  paused;
        bit  calm;
        int  pick;
        paused   = 1'b0;
        calm     = 1'b0;
        ell_live = 1'b0;
        ell_x    = '0;
        ell_y    = '1;
        ell_err  = '0;
        ell_asq  = '0;
        ell_bsq  = '0;
        ell_cx   = '0;
        ell_cy   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_busy = 1'b1;
        rx_busy = 1'b1;
        for (int i = 0; i < DIR_ROWS; i++)
            issue(dir_tab[i]);

        while (live_items < NUM_ITEMS) begin
            calm    = (live_items > NUM_ITEMS - CALM_ITEMS);
            tx_busy = !calm && ($urandom_range(0, 2) != 0);
            rx_busy = !calm && ($urandom_range(0, 2) != 0);
            if (!paused && live_items >= NUM_ITEMS / 2) begin
                // hold the sender until every booked point has been seen
                paused = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_pts.size() != 0);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                issue(rand_row(1'($urandom_range(0, 1)), (1 << AW) - 1));
            end else if (pick == 1) begin
                // wide ellipse, walked a little then abandoned
                issue(rand_row(ebr_pkg::REQ_START, (1 << AW) - 1));
                steps = $urandom_range(2, 20);
                for (int s = 0; s < steps; s++)
                    issue(rand_row(ebr_pkg::REQ_NEXT, (1 << AW) - 1));
            end else begin
                issue(rand_row(ebr_pkg::REQ_START, 24));
                steps = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 1 << 30;
                for (int s = 0; ell_live && s < steps; s++)
                    issue(rand_row(ebr_pkg::REQ_NEXT, (1 << AW) - 1));
                if (!ell_live && $urandom_range(0, 3) == 0)
                    issue(rand_row(ebr_pkg::REQ_NEXT, (1 << AW) - 1));
            end
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending_pts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
